FILE: src/zoned_free_frame_allocator_defines.svh
// Assertion macros for the zoned free frame allocator.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ZONED_FREE_FRAME_ALLOCATOR_DEFINES_SVH
`define ZONED_FREE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZFFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("zffa: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ZFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("zffa: assertion failed");

`endif

FILE: src/zffa_pkg.sv
// Shared types and constants of the zoned free frame allocator.
// No dependencies.
`default_nettype none

package zffa_pkg;

	localparam int FRAME_W   = 40;
	localparam int ZONE_IN_W = 2;
	localparam int ZONE_W    = 3;   // holds any zone index up to the largest zone count
	localparam int CFG_COUNT = 3;
	localparam int CFG_IDX_W = 2;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [ZONE_W-1:0]  zone_idx_t;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ZONE0_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE1_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE2_LIMIT = 2'd2;

	localparam frame_t ZONE0_LIMIT_RST = 40'd4095;
	localparam frame_t ZONE1_LIMIT_RST = 40'd1048575;
	localparam frame_t ZONE2_LIMIT_RST = 40'hFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_ABOVE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Zone decision handed from the selector to the datapath.
	typedef struct packed {
		logic      push_found;
		logic      push_full;
		zone_idx_t push_zone;
		logic      pop_found;
		zone_idx_t pop_zone;
	} zone_sel_t;

endpackage

`default_nettype wire

FILE: src/zffa_req_if.sv
// Request channel of the allocator: valid/ready plus request payload.
// Depends on zffa_pkg.
`default_nettype none

interface zffa_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [zffa_pkg::ZONE_IN_W-1:0] zone;
	zffa_pkg::frame_t               frame_number;

	modport source (output valid, action, zone, frame_number, input ready);
	modport sink   (input valid, action, zone, frame_number, output ready);
endinterface

`default_nettype wire

FILE: src/zffa_rsp_if.sv
// Result channel of the allocator: valid/ready plus result payload.
// Depends on zffa_pkg.
`default_nettype none

interface zffa_rsp_if;
	logic             valid;
	logic             ready;
	zffa_pkg::frame_t granted_frame;
	logic [1:0]       status;

	modport source (output valid, granted_frame, status, input ready);
	modport sink   (input valid, granted_frame, status, output ready);
endinterface

`default_nettype wire

FILE: src/zffa_zone_sel.sv
// Zone selection: home zone of a freed frame and source zone of an allocation.
// Depends on zffa_pkg.
`default_nettype none

module zffa_zone_sel #(
	parameter int ZONES = 3
) (
	input  var zffa_pkg::frame_t               limit [ZONES],
	input  var logic [ZONES-1:0]               empty,
	input  var logic [ZONES-1:0]               full,
	input  var zffa_pkg::frame_t               frame_number,
	input  var logic [zffa_pkg::ZONE_IN_W-1:0] zone,
	output zffa_pkg::zone_sel_t                sel
);

	localparam int ZIDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;

	zffa_pkg::zone_idx_t zmax;

	// out-of-range request zone saturates to the top zone
	always_comb begin
		if (int'(zone) >= ZONES) begin
			zmax = zffa_pkg::ZONE_W'(ZONES - 1);
		end else begin
			zmax = zffa_pkg::ZONE_W'(zone);
		end
	end

	always_comb begin
		sel = '0;
		// descending so the lowest matching zone wins
		for (int z = ZONES - 1; z >= 0; z--) begin
			if (frame_number <= limit[z]) begin
				sel.push_found = 1'b1;
				sel.push_zone  = zffa_pkg::ZONE_W'(z);
			end
		end
		sel.push_full = full[sel.push_zone[ZIDX_W-1:0]];
		// ascending so the highest eligible non-empty zone wins
		for (int z = 0; z < ZONES; z++) begin
			if (zffa_pkg::ZONE_W'(z) <= zmax && !empty[z]) begin
				sel.pop_found = 1'b1;
				sel.pop_zone  = zffa_pkg::ZONE_W'(z);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/zoned_free_frame_allocator.sv
// Zoned free frame allocator, top level. A request passes the stack read, then
// the result register. Throughput: one request per cycle while rsp.ready holds;
// the single stack memory takes one push or one pop per cycle.
// Reset: asynchronous, active low; all stacks empty, limits at defaults.
// Stack memory contents are not reset; fill counters gate every read.
// Depends on zffa_pkg, zffa_req_if, zffa_rsp_if, zffa_zone_sel, defines header.
`default_nettype none
`include "zoned_free_frame_allocator_defines.svh"

module zoned_free_frame_allocator #(
	parameter int ZONES       = 3,
	parameter int STACK_DEPTH = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [zffa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire zffa_pkg::frame_t               cfg_data,
	zffa_req_if.sink                            req,
	zffa_rsp_if.source                          rsp
);

	localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int ENTRIES = ZONES * STACK_DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int ZIDX_W  = (ZONES > 1) ? $clog2(ZONES) : 1;

	// ---------------- configuration: zone limits ----------------
	zffa_pkg::frame_t limit_q [zffa_pkg::CFG_COUNT];
	zffa_pkg::frame_t limit   [ZONES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q[0] <= zffa_pkg::ZONE0_LIMIT_RST;
			limit_q[1] <= zffa_pkg::ZONE1_LIMIT_RST;
			limit_q[2] <= zffa_pkg::ZONE2_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zffa_pkg::CFG_ZONE0_LIMIT: limit_q[0] <= cfg_data;
				zffa_pkg::CFG_ZONE1_LIMIT: limit_q[1] <= cfg_data;
				zffa_pkg::CFG_ZONE2_LIMIT: limit_q[2] <= cfg_data;
				default: ;  // index past the register list: dropped
			endcase
		end
	end

	// zones beyond the configurable ones cover the whole frame space
	for (genvar z = 0; z < ZONES; z++) begin : g_limit
		if (z < zffa_pkg::CFG_COUNT) begin : g_cfg
			assign limit[z] = limit_q[z];
		end else begin : g_open
			assign limit[z] = '1;
		end
	end

	// ---------------- fill counters ----------------
	logic [FILL_W-1:0] fill_q [ZONES];
	logic [ZONES-1:0]  empty;
	logic [ZONES-1:0]  full;
	logic [ZONES-1:0]  fill_over;

	for (genvar z = 0; z < ZONES; z++) begin : g_flags
		assign empty[z]     = (fill_q[z] == '0);
		assign full[z]      = (fill_q[z] == FILL_W'(STACK_DEPTH));
		assign fill_over[z] = (fill_q[z] > FILL_W'(STACK_DEPTH));
	end

	zffa_pkg::zone_sel_t sel;

	zffa_zone_sel #(
		.ZONES (ZONES)
	) u_zone_sel (
		.limit        (limit),
		.empty        (empty),
		.full         (full),
		.frame_number (req.frame_number),
		.zone         (req.zone),
		.sel          (sel)
	);

	// ---------------- handshake and decision ----------------
	logic                valid_s1;
	logic                pop_s1;
	zffa_pkg::status_t   status_s1;
	zffa_pkg::frame_t    rd_data_s1;
	logic                out_valid_q;
	zffa_pkg::frame_t    out_frame_q;
	zffa_pkg::status_t   out_status_q;
	logic                out_adv;
	logic                acc;
	logic                is_free;
	logic                push_ok;
	logic                pop_ok;
	zffa_pkg::status_t   status_d;
	logic [ZIDX_W-1:0]   push_idx;
	logic [ZIDX_W-1:0]   pop_idx;

	// result register frees up when empty or drained this cycle
	assign out_adv   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || out_adv;
	assign acc       = req.valid && req.ready;
	assign is_free   = (req.action == zffa_pkg::ACT_FREE);
	assign push_ok   = is_free && sel.push_found && !sel.push_full;
	assign pop_ok    = !is_free && sel.pop_found;
	assign push_idx  = sel.push_zone[ZIDX_W-1:0];
	assign pop_idx   = sel.pop_zone[ZIDX_W-1:0];

	always_comb begin
		if (is_free) begin
			if (!sel.push_found) begin
				status_d = zffa_pkg::ST_ABOVE;
			end else if (sel.push_full) begin
				status_d = zffa_pkg::ST_FULL;
			end else begin
				status_d = zffa_pkg::ST_OK;
			end
		end else begin
			status_d = pop_ok ? zffa_pkg::ST_OK : zffa_pkg::ST_OOM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int z = 0; z < ZONES; z++) begin
				fill_q[z] <= '0;
			end
		end else if (acc) begin
			if (push_ok) begin
				fill_q[push_idx] <= fill_q[push_idx] + FILL_W'(1);
			end else if (pop_ok) begin
				fill_q[pop_idx] <= fill_q[pop_idx] - FILL_W'(1);
			end
		end
	end

	// ---------------- stack memory ----------------
	// Zone z owns entries z*STACK_DEPTH upward. Push writes at fill, pop reads
	// at fill-1. A pop right after a push reads after the write has landed, and a
	// push right after a pop writes after the read, so no forwarding.
	logic [PTR_W-1:0]  push_ptr;
	logic [PTR_W-1:0]  pop_ptr;
	logic [FILL_W-1:0] pop_fill_m1;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	zffa_pkg::frame_t  stack_mem [ENTRIES];

	assign push_ptr    = fill_q[push_idx][PTR_W-1:0];
	assign pop_fill_m1 = fill_q[pop_idx] - FILL_W'(1);
	assign pop_ptr     = pop_fill_m1[PTR_W-1:0];
	assign wr_addr     = ADDR_W'(sel.push_zone) * ADDR_W'(STACK_DEPTH) + ADDR_W'(push_ptr);
	assign rd_addr     = ADDR_W'(sel.pop_zone) * ADDR_W'(STACK_DEPTH) + ADDR_W'(pop_ptr);

	always_ff @(posedge clk) begin
		if (acc && push_ok) begin
			stack_mem[wr_addr] <= req.frame_number;
		end
		if (acc && pop_ok) begin
			rd_data_s1 <= stack_mem[rd_addr];
		end
	end

	// ---------------- stage 1 and result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pop_s1    <= pop_ok;
			status_s1 <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// read data holds while stage 1 stalls: no new pop can be accepted then
	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_frame_q  <= pop_s1 ? rd_data_s1 : '0;
			out_status_q <= status_s1;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_frame = out_frame_q;
	assign rsp.status        = out_status_q;

	// ---------------- checks ----------------
	`ZFFA_ASSERT_IMPLY(a_fill_bound, clk, arst_n, 1'b1, fill_over == '0)
	`ZFFA_ASSERT_NEXT(a_pop_tracked, clk, arst_n, acc && pop_ok, valid_s1 && pop_s1)
	`ZFFA_ASSERT_IMPLY(a_grant_needs_ok, clk, arst_n,
		out_valid_q && out_status_q != zffa_pkg::ST_OK, out_frame_q == '0)

endmodule

`default_nettype wire
